FILE: rtl/ugw_pkg.sv
// Shared types, codes and UTF-8 helper functions for the glyph lookup block.
// Depends on nothing; used by utf8_glyph_lookup_width.
`default_nettype none

package ugw_pkg;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TEXT = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    localparam logic [1:0] REG_GAP_WIDTH   = 2'd0;
    localparam logic [1:0] REG_GLYPH_COUNT = 2'd1;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;
    localparam int CODE_BITS      = 18;

    localparam logic [7:0]  ASCII_MAX    = 8'h7F;
    localparam logic [7:0]  LEAD_MIN     = 8'hC0;
    localparam logic [7:0]  LEAD2_LOW    = 8'hC2;
    localparam logic [7:0]  LEAD2_HIGH   = 8'hDF;
    localparam logic [3:0]  LEAD3_NIBBLE = 4'hE;
    localparam logic [7:0]  LEAD4_BYTE   = 8'hF0;
    localparam logic [1:0]  CONT_TAG     = 2'b10;
    localparam logic [15:0] MIN_THREE    = 16'h0800;
    localparam logic [17:0] MIN_FOUR     = 18'h10000;

    typedef logic [CODE_BITS-1:0] code_t;

    typedef struct packed {
        logic  ok;
        code_t key;
    } decode_t;

    function automatic logic [3:0] lead_length(input logic [7:0] b);
        logic [3:0] n;
        logic       stop;
        n    = 4'd0;
        stop = 1'b0;
        if (b < LEAD_MIN)
        begin
            n = 4'd1;
        end
        else
        begin
            for (int i = 7; i >= 0; i--)
            begin
                if (!stop && b[i])
                begin
                    n = n + 4'd1;
                end
                else
                begin
                    stop = 1'b1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == CONT_TAG;
    endfunction

    // A key exists only for canonically encoded sequences of one to four bytes.
    function automatic decode_t decode_key(input logic [31:0] bytes, input logic [3:0] count);
        decode_t    d;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [15:0] c3;
        code_t      c4;
        b0 = bytes[7:0];
        b1 = bytes[15:8];
        b2 = bytes[23:16];
        b3 = bytes[31:24];
        c3 = {b0[3:0], b1[5:0], b2[5:0]};
        c4 = {b1[5:0], b2[5:0], b3[5:0]};
        d.ok  = 1'b0;
        d.key = '0;
        unique case (count)
            4'd1:
            begin
                d.ok  = (b0 <= ASCII_MAX);
                d.key = code_t'(b0);
            end
            4'd2:
            begin
                d.ok  = (b0 >= LEAD2_LOW) && (b0 <= LEAD2_HIGH) && is_cont(b1);
                d.key = code_t'({b0[4:0], b1[5:0]});
            end
            4'd3:
            begin
                d.ok  = (b0[7:4] == LEAD3_NIBBLE) && is_cont(b1) && is_cont(b2)
                        && (c3 >= MIN_THREE);
                d.key = code_t'(c3);
            end
            4'd4:
            begin
                d.ok  = (b0 == LEAD4_BYTE) && is_cont(b1) && is_cont(b2) && is_cont(b3)
                        && (c4 >= MIN_FOUR);
                d.key = c4;
            end
            default:
            begin
                d.ok  = 1'b0;
                d.key = '0;
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/utf8_glyph_lookup_width.sv
// Glyph table lookup for UTF-8 text with a saturating width sum, using ugw_pkg.
// A load item or a byte that does not end a character is taken in the idle state; a byte that
// ends one goes through the decode, search (one table read per probe) and, if a candidate is
// left, check states; the emit state registers its result once the output slot is free.
// No item is taken while a character is in flight; an end item flushes a partial one first.
// Reset clears the gather state, the width sum and both registers; the table is not cleared.
`default_nettype none

module utf8_glyph_lookup_width #(
    parameter int TABLE_DEPTH    = 256,
    parameter int FIRST_SEARCHED = 2,
    parameter int WIDTH_BITS     = 8,
    parameter int SUM_BITS       = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          command,
    input  wire logic [7:0]                          entry_index,
    input  wire logic [17:0]                         entry_code,
    input  wire logic [7:0]                          entry_width,
    input  wire logic [7:0]                          text_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     result_kind,
    output logic [7:0]                               glyph_index,
    output logic [7:0]                               glyph_width,
    output logic [15:0]                              running_width,
    output logic                                     last,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ugw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [ugw_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADD_W  = ((SUM_BITS > 16) ? SUM_BITS : 16) + 2;
    localparam logic [CNT_W-1:0]    FIRST_CNT = CNT_W'(FIRST_SEARCHED);
    localparam logic [CNT_W-1:0]    DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [SUM_BITS-1:0] SUM_MAX   = {SUM_BITS{1'b1}};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_TOTAL  = 3'd5;

    logic [ugw_pkg::CODE_BITS-1:0] code_mem [TABLE_DEPTH];
    logic [WIDTH_BITS-1:0]         width_mem [TABLE_DEPTH];
    logic [ugw_pkg::CODE_BITS-1:0] code_q;
    logic [WIDTH_BITS-1:0]         width_q;

    logic [2:0]            state_reg, state_next;
    logic [31:0]           pending_reg, pending_next;
    logic [3:0]            gathered_reg, gathered_next;
    logic [3:0]            needed_reg, needed_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [7:0]            gap_reg;
    logic [8:0]            count_reg;
    ugw_pkg::code_t        key_reg, key_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [CNT_W-1:0]      mid_reg, mid_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic                  total_pend_reg, total_pend_next;
    logic                  out_valid_reg;

    logic                  in_fire;
    logic                  slot_free;
    logic                  load_glyph;
    logic                  load_total;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    ugw_pkg::decode_t      dec;
    logic [CNT_W-1:0]      hi_init;
    logic [CNT_W-1:0]      probe_lo;
    logic [CNT_W-1:0]      probe_hi;
    logic [CNT_W-1:0]      cand;
    logic [3:0]            byte_needed;
    logic [3:0]            byte_count;
    logic [ADD_W-1:0]      sum_wide;
    logic [SUM_BITS-1:0]   sum_sat;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign wr_en   = in_fire && (command == ugw_pkg::CMD_LOAD)
                     && (32'(entry_index) < TABLE_DEPTH);
    assign wr_addr = ADDR_W'(entry_index);

    assign dec     = ugw_pkg::decode_key(pending_reg, gathered_reg);
    assign hi_init = (32'(count_reg) < TABLE_DEPTH) ? CNT_W'(count_reg) : DEPTH_CNT;

    assign probe_lo = (key_reg < code_q) ? lo_reg : mid_reg + CNT_W'(1);
    assign probe_hi = (key_reg < code_q) ? mid_reg : hi_reg;
    assign cand     = lo_reg - CNT_W'(1);

    assign byte_needed = (gathered_reg == 4'd0) ? ugw_pkg::lead_length(text_byte) : needed_reg;
    assign byte_count  = gathered_reg + 4'd1;

    assign sum_wide = ADD_W'(sum_reg) + ADD_W'(width_q) + ADD_W'(gap_reg);
    assign sum_sat  = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(sum_wide);

    always_comb
    begin
        state_next      = state_reg;
        pending_next    = pending_reg;
        gathered_next   = gathered_reg;
        needed_next     = needed_reg;
        sum_next        = sum_reg;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        total_pend_next = total_pend_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        load_glyph      = 1'b0;
        load_total      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (command == ugw_pkg::CMD_TEXT))
                begin
                    needed_next   = byte_needed;
                    gathered_next = byte_count;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (gathered_reg == 4'(k))
                        begin
                            pending_next[8*k +: 8] = pending_reg[8*k +: 8] | text_byte;
                        end
                    end
                    if (byte_count >= byte_needed)
                    begin
                        total_pend_next = 1'b0;
                        state_next      = S_DECODE;
                    end
                end
                else if (in_fire && (command == ugw_pkg::CMD_END))
                begin
                    if (gathered_reg != 4'd0)
                    begin
                        idx_next        = '0;
                        rd_en           = 1'b1;
                        total_pend_next = 1'b1;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_TOTAL;
                    end
                end
            end
            S_DECODE:
            begin
                key_next = dec.key;
                lo_next  = FIRST_CNT;
                hi_next  = hi_init;
                mid_next = FIRST_CNT + CNT_W'((hi_init - FIRST_CNT) >> 1);
                rd_en    = 1'b1;
                if (dec.ok && (FIRST_CNT < hi_init))
                begin
                    rd_addr    = mid_next[ADDR_W-1:0];
                    state_next = S_SEARCH;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_SEARCH:
            begin
                lo_next  = probe_lo;
                hi_next  = probe_hi;
                mid_next = probe_lo + CNT_W'((probe_hi - probe_lo) >> 1);
                rd_en    = 1'b1;
                if (probe_lo < probe_hi)
                begin
                    rd_addr = mid_next[ADDR_W-1:0];
                end
                else if (probe_lo > FIRST_CNT)
                begin
                    rd_addr    = ADDR_W'(probe_lo - CNT_W'(1));
                    state_next = S_CHECK;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_CHECK:
            begin
                if (code_q == key_reg)
                begin
                    idx_next = cand[ADDR_W-1:0];
                end
                else
                begin
                    idx_next = '0;
                    rd_en    = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    load_glyph    = 1'b1;
                    sum_next      = sum_sat;
                    pending_next  = '0;
                    gathered_next = '0;
                    needed_next   = '0;
                    state_next    = total_pend_reg ? S_TOTAL : S_IDLE;
                end
            end
            S_TOTAL:
            begin
                if (slot_free)
                begin
                    load_total    = 1'b1;
                    sum_next      = '0;
                    pending_next  = '0;
                    gathered_next = '0;
                    needed_next   = '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_mem[wr_addr]  <= entry_code;
            width_mem[wr_addr] <= WIDTH_BITS'(entry_width);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            code_q  <= code_mem[rd_addr];
            width_q <= width_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pending_reg    <= '0;
            gathered_reg   <= '0;
            needed_reg     <= '0;
            sum_reg        <= '0;
            gap_reg        <= '0;
            count_reg      <= '0;
            total_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pending_reg    <= pending_next;
            gathered_reg   <= gathered_next;
            needed_reg     <= needed_next;
            sum_reg        <= sum_next;
            total_pend_reg <= total_pend_next;
            if (load_glyph || load_total)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ugw_pkg::REG_GAP_WIDTH)
                begin
                    gap_reg <= cfg_data[7:0];
                end
                else if (cfg_index == ugw_pkg::REG_GLYPH_COUNT)
                begin
                    count_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        idx_reg <= idx_next;
        if (load_glyph)
        begin
            result_kind   <= ugw_pkg::KIND_GLYPH;
            glyph_index   <= 8'(idx_reg);
            glyph_width   <= 8'(width_q);
            running_width <= 16'(sum_sat);
            last          <= 1'b0;
        end
        else if (load_total)
        begin
            result_kind   <= ugw_pkg::KIND_TOTAL;
            glyph_index   <= '0;
            glyph_width   <= '0;
            running_width <= 16'(sum_reg);
            last          <= 1'b1;
        end
    end

    // A character is never left complete while the block waits for input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && gathered_reg != 4'd0) |-> (gathered_reg < needed_reg))
        else $error("complete character left in the gather state");

    // The search window stays inside the table while probing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg < hi_reg && hi_reg <= DEPTH_CNT
                                     && mid_reg >= lo_reg && mid_reg < hi_reg))
        else $error("search window out of range");

    // While a total item waits, no glyph has been added since the sum was cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_kind == ugw_pkg::KIND_TOTAL) |-> (sum_reg == '0))
        else $error("width sum not cleared after a total item");

    // After a flushed partial character is emitted, the block goes on to the total state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_glyph && total_pend_reg) |=> (state_reg == S_TOTAL))
        else $error("flush did not lead to a total item");

    // The gather count never exceeds the longest lead-byte length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (gathered_reg <= 4'd8) && (needed_reg <= 4'd8))
        else $error("gather count out of range");

endmodule

`default_nettype wire
